// ===== rtl/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// fr_pkg: shared types for the fraction reducer
// Status word passed from the shared divide unit back to the sequencer.
// ----------------------------------------------------------------------------
package fr_pkg;

	typedef struct packed {
		logic done;	// quotient and remainder valid this cycle
	} fr_div_stat_t;

endpackage

// ===== rtl/fr_div.sv =====
// ----------------------------------------------------------------------------
// fr_div: shared restoring divider
// Unsigned magnitude division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fr_div #(
	parameter int MAG_W = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_W-1:0]     dividend,
	input  logic [MAG_W-1:0]     divisor,
	output logic [MAG_W-1:0]     quotient,
	output logic [MAG_W-1:0]     remainder,
	output fr_pkg::fr_div_stat_t stat
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MAG_W:0]   trial;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[MAG_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			cnt_q  <= CNT_W'(MAG_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (trial[MAG_W]) begin
				// negative: restore, shift in zero
				rem_q <= {rem_q[MAG_W-2:0], quo_q[MAG_W-1]};
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/fraction_reducer.sv =====
// ----------------------------------------------------------------------------
// fraction_reducer: reduce a signed fraction to lowest terms
// Flow: after the accepting edge the block runs k Euclid remainder steps
//   (each one restoring division on the shared divider), then divides the
//   numerator and then the denominator by the gcd and raises out_valid
//   with the reduced fraction.
// Throughput: one transaction at a time; the next input is taken only after
//   the result has been taken (out_stall low in S_OUT).
// A zero denominator raises out_valid at the accepting edge; the next input
//   is taken once that result is taken. Reset: asynchronous, clears all.
// ----------------------------------------------------------------------------
module fraction_reducer #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] numerator_in,
	input  logic signed [DATA_WIDTH-1:0] denominator_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] numerator_out,
	output logic        [DATA_WIDTH-2:0] denominator_out,
	output logic                         status
);

	localparam int MAG_W = DATA_WIDTH - 1;

	typedef enum logic [2:0] {
		S_IDLE,	// waiting for a transaction
		S_GCD,	// launch next Euclid step, or the numerator division
		S_GCDW,	// wait for a remainder
		S_DIVN,	// wait for numerator / gcd
		S_DIVD,	// wait for denominator / gcd
		S_OUT	// hold the result until taken
	} state_t;

	state_t               state_q;
	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     b_q;
	logic [MAG_W-1:0]     g_q;
	logic [MAG_W-1:0]     nmag_q;
	logic [MAG_W-1:0]     dmag_q;
	logic [MAG_W-1:0]     qn_q;
	logic                 nsign_q;
	logic                 dsign_q;

	logic                 div_start;
	logic [MAG_W-1:0]     div_dividend;
	logic [MAG_W-1:0]     div_divisor;
	logic [MAG_W-1:0]     div_quo;
	logic [MAG_W-1:0]     div_rem;
	fr_pkg::fr_div_stat_t div_stat;

	logic [DATA_WIDTH-1:0] nneg;
	logic [DATA_WIDTH-1:0] dneg;
	logic [MAG_W-1:0]      nmag;
	logic [MAG_W-1:0]      dmag;
	logic                  accept;
	logic [DATA_WIDTH-1:0] qn_ext;
	logic                  neg;

	// Saturating magnitudes: the most negative code clamps to the largest
	// positive magnitude so no later negation can overflow.
	assign nneg = -numerator_in;
	assign dneg = -denominator_in;
	assign nmag = !numerator_in[DATA_WIDTH-1] ? numerator_in[MAG_W-1:0] :
		(nneg[DATA_WIDTH-1] ? {MAG_W{1'b1}} : nneg[MAG_W-1:0]);
	assign dmag = !denominator_in[DATA_WIDTH-1] ? denominator_in[MAG_W-1:0] :
		(dneg[DATA_WIDTH-1] ? {MAG_W{1'b1}} : dneg[MAG_W-1:0]);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Sign of the reduced fraction: zero numerator always comes out positive.
	assign qn_ext = {1'b0, qn_q};
	assign neg    = (qn_q != '0) && (nsign_q != dsign_q);

	// Operand selection for the shared divider.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = a_q;
		div_divisor  = b_q;
		case (state_q)
			S_GCD: begin
				div_start = 1'b1;
				if (b_q == '0) begin
					// Euclid finished: gcd sits in a, divide the numerator by it
					div_dividend = nmag_q;
					div_divisor  = a_q;
				end
			end
			S_DIVN: begin
				div_start    = div_stat.done;
				div_dividend = dmag_q;
				div_divisor  = g_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	fr_div #(
		.MAG_W (MAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			a_q             <= '0;
			b_q             <= '0;
			g_q             <= '0;
			nmag_q          <= '0;
			dmag_q          <= '0;
			qn_q            <= '0;
			nsign_q         <= 1'b0;
			dsign_q         <= 1'b0;
			out_valid       <= 1'b0;
			numerator_out   <= '0;
			denominator_out <= '0;
			status          <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						nsign_q <= numerator_in[DATA_WIDTH-1];
						dsign_q <= denominator_in[DATA_WIDTH-1];
						nmag_q  <= nmag;
						dmag_q  <= dmag;
						a_q     <= nmag;
						b_q     <= dmag;
						if (denominator_in == '0) begin
							// reject: pass the operands through with the error flag
							numerator_out   <= numerator_in;
							denominator_out <= '0;
							status          <= 1'b1;
							out_valid       <= 1'b1;
							state_q         <= S_OUT;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					if (b_q == '0) begin
						g_q     <= a_q;
						state_q <= S_DIVN;
					end else begin
						state_q <= S_GCDW;
					end
				end
				S_GCDW: begin
					if (div_stat.done) begin
						// advance Euclid: (a, b) <- (b, a mod b)
						a_q     <= b_q;
						b_q     <= div_rem;
						state_q <= S_GCD;
					end
				end
				S_DIVN: begin
					if (div_stat.done) begin
						qn_q    <= div_quo;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_stat.done) begin
						numerator_out   <= neg ? -qn_ext : qn_ext;
						denominator_out <= div_quo;
						status          <= 1'b0;
						out_valid       <= 1'b1;
						state_q         <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
			endcase
		end
	end

endmodule
